// File: rtl/i2cram_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cram_pkg
// Shared types and codes for the I2C register access master.
// ----------------------------------------------------------------------------
package i2cram_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_DONE  = 2'd2,
        CMD_TICK  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_SEND    = 3'd2,
        ACT_RD_ACK  = 3'd3,
        ACT_RD_NACK = 3'd4,
        ACT_STOP    = 3'd5,
        ACT_RELEASE = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        RES_BUSY       = 3'd0,
        RES_WRITE_OK   = 3'd1,
        RES_READ_OK    = 3'd2,
        RES_CONN_ERR   = 3'd3,
        RES_TIMEOUT    = 3'd4,
        RES_STATUS_ERR = 3'd5
    } t_res_code;

    // engine status codes (upper five bits of the status byte)
    localparam logic [4:0] ST_START_SENT   = 5'd1;
    localparam logic [4:0] ST_RESTART_SENT = 5'd2;
    localparam logic [4:0] ST_ADDR_W_ACK   = 5'd3;
    localparam logic [4:0] ST_ADDR_W_NACK  = 5'd4;
    localparam logic [4:0] ST_DATA_ACK     = 5'd5;
    localparam logic [4:0] ST_DATA_NACK    = 5'd6;
    localparam logic [4:0] ST_ADDR_R_ACK   = 5'd8;
    localparam logic [4:0] ST_ADDR_R_NACK  = 5'd9;
    localparam logic [4:0] ST_RX_ACK       = 5'd10;
    localparam logic [4:0] ST_RX_NACK      = 5'd11;

    localparam logic       RD_BIT          = 1'b1;
    localparam logic [7:0] TIMEOUT_RESET   = 8'd10;

    typedef struct packed {
        t_cmd       command;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic [7:0] read_length;
        logic [4:0] bus_status_in;
        logic [7:0] received_byte;
    } t_req;

    typedef struct packed {
        t_action    bus_action;
        logic [7:0] send_byte;
        logic [7:0] read_data;
        logic       read_valid;
        logic       last_byte;
        logic       finished;
        t_res_code  result_code;
        logic [4:0] error_status;
    } t_result;

endpackage

// File: rtl/i2cram_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cram_fsm
// Transaction sequencer: takes one word per advance, updates the transaction
// state and produces the matching bus action and result.
// ----------------------------------------------------------------------------
module i2cram_fsm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  i2cram_pkg::t_req    i_req,
    input  logic [7:0]          i_timeout_limit,
    output i2cram_pkg::t_result o_result
);
    import i2cram_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START     = 4'd1,
        PH_ADDR_W    = 4'd2,
        PH_REG       = 4'd3,
        PH_DATA      = 4'd4,
        PH_STOP      = 4'd5,
        PH_RESTART   = 4'd6,
        PH_ADDR_R    = 4'd7,
        PH_READ      = 4'd8,
        PH_NACK_STOP = 4'd9
    } t_phase;

    t_phase     r_phase,    n_phase;
    logic [7:0] r_wait,     n_wait;
    logic [6:0] r_device,   n_device;
    logic [7:0] r_register, n_register;
    logic [7:0] r_wr_byte,  n_wr_byte;
    logic [7:0] r_left,     n_left;
    logic       r_rd_mode,  n_rd_mode;
    logic [4:0] r_pend_err, n_pend_err;

    t_result    w_res;
    logic [4:0] w_st;
    logic [7:0] w_addr;
    logic [7:0] w_left_dec;

    function automatic t_action read_act(input logic [7:0] left);
        t_action act;
        if (left == 8'd0) begin
            act = ACT_STOP;
        end else if (left == 8'd1) begin
            act = ACT_RD_NACK;
        end else begin
            act = ACT_RD_ACK;
        end
        return act;
    endfunction

    assign w_st       = i_req.bus_status_in;
    assign w_addr     = {r_device, 1'b0};
    assign w_left_dec = r_left - 8'd1;

    always_comb begin
        n_phase    = r_phase;
        n_wait     = r_wait;
        n_device   = r_device;
        n_register = r_register;
        n_wr_byte  = r_wr_byte;
        n_left     = r_left;
        n_rd_mode  = r_rd_mode;
        n_pend_err = r_pend_err;
        w_res      = '0;

        case (i_req.command)
            CMD_WRITE, CMD_READ: begin
                if (r_phase == PH_IDLE) begin
                    n_device   = i_req.device_address;
                    n_register = i_req.register_address;
                    n_wr_byte  = i_req.write_data;
                    n_rd_mode  = (i_req.command == CMD_READ);
                    n_left     = (i_req.command == CMD_READ) ? i_req.read_length : 8'd0;
                    n_pend_err = '0;
                    w_res.bus_action = ACT_START;
                    n_phase    = PH_START;
                    n_wait     = '0;
                end
            end
            CMD_DONE: begin
                case (r_phase)
                    PH_START, PH_RESTART: begin
                        if (w_st inside {ST_START_SENT, ST_RESTART_SENT}) begin
                            w_res.bus_action = ACT_SEND;
                            if (r_phase == PH_START) begin
                                w_res.send_byte = w_addr;
                                n_phase = PH_ADDR_W;
                            end else begin
                                w_res.send_byte = w_addr | {7'd0, RD_BIT};
                                n_phase = PH_ADDR_R;
                            end
                            n_wait = '0;
                        end else begin
                            w_res.bus_action   = ACT_RELEASE;
                            w_res.finished     = 1'b1;
                            w_res.result_code  = RES_STATUS_ERR;
                            w_res.error_status = w_st;
                            n_phase = PH_IDLE;
                            n_wait  = '0;
                        end
                    end
                    PH_ADDR_W, PH_ADDR_R: begin
                        if (w_st inside {ST_ADDR_W_ACK, ST_ADDR_R_ACK}) begin
                            if (r_phase == PH_ADDR_W) begin
                                w_res.bus_action = ACT_SEND;
                                w_res.send_byte  = r_register;
                                n_phase = PH_REG;
                            end else begin
                                w_res.bus_action = read_act(r_left);
                                n_phase = (r_left == 8'd0) ? PH_STOP : PH_READ;
                            end
                            n_wait = '0;
                        end else if (w_st inside {ST_ADDR_W_NACK, ST_ADDR_R_NACK}) begin
                            n_pend_err = w_st;
                            w_res.bus_action = ACT_STOP;
                            n_phase = PH_NACK_STOP;
                            n_wait  = '0;
                        end else begin
                            w_res.bus_action   = ACT_RELEASE;
                            w_res.finished     = 1'b1;
                            w_res.result_code  = RES_STATUS_ERR;
                            w_res.error_status = w_st;
                            n_phase = PH_IDLE;
                            n_wait  = '0;
                        end
                    end
                    PH_REG, PH_DATA: begin
                        if (w_st == ST_DATA_ACK) begin
                            if (r_phase == PH_DATA) begin
                                w_res.bus_action = ACT_STOP;
                                n_phase = PH_STOP;
                            end else if (r_rd_mode) begin
                                w_res.bus_action = ACT_START;
                                n_phase = PH_RESTART;
                            end else begin
                                w_res.bus_action = ACT_SEND;
                                w_res.send_byte  = r_wr_byte;
                                n_phase = PH_DATA;
                            end
                            n_wait = '0;
                        end else if (w_st == ST_DATA_NACK) begin
                            n_pend_err = w_st;
                            w_res.bus_action = ACT_STOP;
                            n_phase = PH_NACK_STOP;
                            n_wait  = '0;
                        end else begin
                            w_res.bus_action   = ACT_RELEASE;
                            w_res.finished     = 1'b1;
                            w_res.result_code  = RES_STATUS_ERR;
                            w_res.error_status = w_st;
                            n_phase = PH_IDLE;
                            n_wait  = '0;
                        end
                    end
                    PH_READ: begin
                        if (w_st == ((r_left == 8'd1) ? ST_RX_NACK : ST_RX_ACK)) begin
                            w_res.read_data  = i_req.received_byte;
                            w_res.read_valid = 1'b1;
                            w_res.last_byte  = (r_left == 8'd1);
                            n_left = w_left_dec;
                            w_res.bus_action = read_act(w_left_dec);
                            n_phase = (w_left_dec == 8'd0) ? PH_STOP : PH_READ;
                            n_wait  = '0;
                        end else begin
                            w_res.bus_action   = ACT_RELEASE;
                            w_res.finished     = 1'b1;
                            w_res.result_code  = RES_STATUS_ERR;
                            w_res.error_status = w_st;
                            n_phase = PH_IDLE;
                            n_wait  = '0;
                        end
                    end
                    PH_STOP: begin
                        w_res.finished    = 1'b1;
                        w_res.result_code = r_rd_mode ? RES_READ_OK : RES_WRITE_OK;
                        n_phase = PH_IDLE;
                        n_wait  = '0;
                    end
                    PH_NACK_STOP: begin
                        w_res.finished     = 1'b1;
                        w_res.result_code  = RES_STATUS_ERR;
                        w_res.error_status = r_pend_err;
                        n_phase = PH_IDLE;
                        n_wait  = '0;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                if (r_phase != PH_IDLE) begin
                    if (r_wait < i_timeout_limit) begin
                        n_wait = r_wait + 8'd1;
                    end else begin
                        w_res.finished = 1'b1;
                        if (r_phase == PH_START || r_phase == PH_RESTART) begin
                            w_res.result_code = RES_CONN_ERR;
                        end else if (r_phase == PH_NACK_STOP) begin
                            w_res.result_code  = RES_STATUS_ERR;
                            w_res.error_status = r_pend_err;
                        end else begin
                            w_res.result_code = RES_TIMEOUT;
                        end
                        n_phase = PH_IDLE;
                        n_wait  = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_wait     <= '0;
            r_device   <= '0;
            r_register <= '0;
            r_wr_byte  <= '0;
            r_left     <= '0;
            r_rd_mode  <= 1'b0;
            r_pend_err <= '0;
        end else if (i_advance) begin
            r_phase    <= n_phase;
            r_wait     <= n_wait;
            r_device   <= n_device;
            r_register <= n_register;
            r_wr_byte  <= n_wr_byte;
            r_left     <= n_left;
            r_rd_mode  <= n_rd_mode;
            r_pend_err <= n_pend_err;
        end
    end

    assign o_result = w_res;

endmodule

// File: rtl/i2c_register_access_master_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_access_master_unit
// I2C register read/write sequencer. Every request, engine event or wait tick
// yields exactly one result word carrying the next bus action and status.
// ----------------------------------------------------------------------------
// Throughput is one word per clock while the input side is not stalled. A
// word is captured in the input register and then handled by the sequencer,
// which loads the result register. The input side stalls only when both
// registers are full and the output side is stalling. The timeout limit is
// written through the configuration port and must only change while no
// transaction is in flight.
module i2c_register_access_master_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [6:0] i_device_address,
    input  logic [7:0] i_register_address,
    input  logic [7:0] i_write_data,
    input  logic [7:0] i_read_length,
    input  logic [4:0] i_bus_status_in,
    input  logic [7:0] i_received_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_bus_action,
    output logic [7:0] o_send_byte,
    output logic [7:0] o_read_data,
    output logic       o_read_valid,
    output logic       o_last_byte,
    output logic       o_finished,
    output logic [2:0] o_result_code,
    output logic [4:0] o_error_status
);
    import i2cram_pkg::*;

    logic       r_in_valid;
    t_req       r_in;
    t_req       n_in;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    logic [7:0] r_timeout_limit;
    logic       w_out_free;
    logic       w_advance;
    logic       w_in_accept;

    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_advance   = r_in_valid && w_out_free;
    assign o_stall     = r_in_valid && !w_out_free;
    assign w_in_accept = i_valid && !o_stall;

    always_comb begin
        n_in.command          = t_cmd'(i_command);
        n_in.device_address   = i_device_address;
        n_in.register_address = i_register_address;
        n_in.write_data       = i_write_data;
        n_in.read_length      = i_read_length;
        n_in.bus_status_in    = i_bus_status_in;
        n_in.received_byte    = i_received_byte;
    end

    i2cram_fsm u_fsm (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (w_advance),
        .i_req           (r_in),
        .i_timeout_limit (r_timeout_limit),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_timeout_limit <= TIMEOUT_RESET;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= w_advance;
            end
            if (i_cfg_wr_en) begin
                r_timeout_limit <= i_cfg_wr_data;
            end
        end
        if (w_in_accept) begin
            r_in <= n_in;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_bus_action   = r_out.bus_action;
    assign o_send_byte    = r_out.send_byte;
    assign o_read_data    = r_out.read_data;
    assign o_read_valid   = r_out.read_valid;
    assign o_last_byte    = r_out.last_byte;
    assign o_finished     = r_out.finished;
    assign o_result_code  = r_out.result_code;
    assign o_error_status = r_out.error_status;

    // a finished word never carries a start, send, read or stop
    a_finish_action : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |->
            (o_bus_action == ACT_NONE || o_bus_action == ACT_RELEASE))
        else $error("finished word with active bus action");

    a_busy_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_finished) |-> (o_result_code == RES_BUSY))
        else $error("result code without finish");

    a_read_open : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_read_valid) |->
            (!o_finished && (o_bus_action == ACT_RD_ACK ||
             o_bus_action == ACT_RD_NACK || o_bus_action == ACT_STOP)))
        else $error("read byte with wrong follow-up action");

    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output free");

endmodule
